FILE: sv/pei_pkg.sv
// Shared types, constants and helpers for the particle Euler integrator.
`default_nettype none
package pei_pkg;

  localparam int unsigned AXES     = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned MASS_W   = 31;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned SPAN_W   = 31;
  localparam int unsigned IN_W     = 96;
  localparam int unsigned OUT_W    = 200;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned RIDX_W   = 3;

  // Radix-4 divider over a 48-bit dividend.
  localparam int unsigned DIVD_W    = 48;
  localparam int unsigned DIV_STEPS = DIVD_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Item function codes.
  localparam logic [FUNC_W-1:0] FN_FORCE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INTEG = 3'd1;
  localparam logic [FUNC_W-1:0] FN_KILL  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SPAWN = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SETV  = 3'd4;

  // Register indexes.
  localparam logic [RIDX_W-1:0] REG_ACCEL_X = 3'd0;
  localparam logic [RIDX_W-1:0] REG_ACCEL_Y = 3'd1;
  localparam logic [RIDX_W-1:0] REG_ACCEL_Z = 3'd2;
  localparam logic [RIDX_W-1:0] REG_MASS    = 3'd3;
  localparam logic [RIDX_W-1:0] REG_DAMP    = 3'd4;
  localparam logic [RIDX_W-1:0] REG_DT      = 3'd5;
  localparam logic [RIDX_W-1:0] REG_SPAN    = 3'd6;

  // Register reset values.
  localparam logic [MASS_W-1:0] MASS_ONE   = 31'd65536;
  localparam logic [FRAC_W-1:0] DAMP_RST   = 17'd65536;
  localparam logic [FRAC_W-1:0] DT_RST     = 17'd1092;
  localparam logic [SPAN_W-1:0] SPAN_RST   = 31'd327680;

  typedef struct packed {
    logic              start;
    logic [FUNC_W-1:0] func;
  } lane_cmd_t;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [FRAC_W-1:0] damp;
    logic [FRAC_W-1:0] dt;
  } lane_cfg_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] vel;
  } lane_sts_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [WORD_W-1:0] sat32(input logic signed [49:0] v);
    logic [WORD_W-1:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/pei_div.sv
// Radix-4 iterative divider: (force * 2^16) / mass, truncated toward zero.
`default_nettype none
module pei_div
  import pei_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [WORD_W-1:0]        force_in,
  input  wire logic [MASS_W-1:0]        mass,
  output logic                          done,
  output logic signed [DIVD_W:0]        quot
);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  neg_r;
  logic [MASS_W-1:0]     rem_r;
  logic [DIVD_W-1:0]     quo_r;
  logic [MASS_W+1:0]     m3_r;
  logic [WORD_W-1:0]     mag;
  logic [MASS_W+1:0]     t, m1, m2, sub;
  logic [1:0]            qd;

  assign mag = force_in[WORD_W-1] ? (~force_in + 32'd1) : force_in;
  assign m1  = {2'b00, mass};
  assign m2  = {1'b0, mass, 1'b0};
  assign t   = {rem_r, quo_r[DIVD_W-1 -: 2]};

  always_comb begin
    if (t >= m3_r) begin
      qd  = 2'd3;
      sub = m3_r;
    end else if (t >= m2) begin
      qd  = 2'd2;
      sub = m2;
    end else if (t >= m1) begin
      qd  = 2'd1;
      sub = m1;
    end else begin
      qd  = 2'd0;
      sub = '0;
    end
  end

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= {mag, 16'd0};
      m3_r  <= m1 + m2;
      neg_r <= force_in[WORD_W-1];
    end else if (run_r) begin
      rem_r <= MASS_W'(t - sub);
      quo_r <= {quo_r[DIVD_W-3:0], qd};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule
`default_nettype wire

FILE: sv/pei_lane.sv
// One axis lane: position, velocity and force state with its own multiplier and divider.
`default_nettype none
module pei_lane
  import pei_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lane_cmd_t         cmd,
  input  wire logic [WORD_W-1:0] value,
  input  wire logic [WORD_W-1:0] accel,
  input  wire lane_cfg_t         cfg,
  output lane_sts_t              sts
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_POS  = 3'd1;
  localparam logic [2:0] L_DIV  = 3'd2;
  localparam logic [2:0] L_M2   = 3'd3;
  localparam logic [2:0] L_NV   = 3'd4;
  localparam logic [2:0] L_M3   = 3'd5;
  localparam logic [2:0] L_VEL  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [WORD_W-1:0]  pos_r, pos_nxt;
  logic [WORD_W-1:0]  vel_r, vel_nxt;
  logic [WORD_W-1:0]  frc_r, frc_nxt;
  logic               done_r, done_nxt;
  logic [WORD_W-1:0]  tmp_r, tmp_nxt;
  logic [49:0]        prod_r, prod_nxt;

  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] mul_p;
  logic               div_start;
  logic               div_done;
  logic signed [DIVD_W:0] div_q;
  logic signed [33:0] prod_sh;

  assign mul_p   = mul_a * mul_b;
  assign prod_sh = $signed(prod_r[49:16]);

  pei_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .force_in (frc_r),
    .mass     (cfg.mass),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    vel_nxt   = vel_r;
    frc_nxt   = frc_r;
    tmp_nxt   = tmp_r;
    prod_nxt  = prod_r;
    done_nxt  = 1'b0;
    div_start = 1'b0;
    mul_a     = $signed(vel_r);
    mul_b     = $signed({1'b0, cfg.dt});
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          case (cmd.func)
            FN_FORCE: begin
              frc_nxt  = sat32(50'($signed(frc_r)) + 50'($signed(value)));
              done_nxt = 1'b1;
            end
            FN_INTEG: begin
              // old velocity times dt, divider runs alongside
              prod_nxt  = mul_p;
              div_start = 1'b1;
              state_nxt = L_POS;
            end
            FN_SPAWN: begin
              pos_nxt  = value;
              done_nxt = 1'b1;
            end
            FN_SETV: begin
              vel_nxt  = value;
              done_nxt = 1'b1;
            end
            default: done_nxt = 1'b1;
          endcase
        end
      end
      L_POS: begin
        pos_nxt   = sat32(50'($signed(pos_r)) + 50'(prod_sh));
        state_nxt = L_DIV;
      end
      L_DIV: begin
        if (div_done) begin
          tmp_nxt   = sat32(50'($signed(accel)) + 50'(div_q));
          state_nxt = L_M2;
        end
      end
      L_M2: begin
        mul_a     = $signed(tmp_r);
        prod_nxt  = mul_p;
        state_nxt = L_NV;
      end
      L_NV: begin
        tmp_nxt   = sat32(50'($signed(vel_r)) + 50'(prod_sh));
        state_nxt = L_M3;
      end
      L_M3: begin
        mul_a     = $signed(tmp_r);
        mul_b     = $signed({1'b0, cfg.damp});
        prod_nxt  = mul_p;
        state_nxt = L_VEL;
      end
      L_VEL: begin
        vel_nxt   = sat32(50'(prod_sh));
        frc_nxt   = '0;
        done_nxt  = 1'b1;
        state_nxt = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      pos_r   <= '0;
      vel_r   <= '0;
      frc_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      vel_r   <= vel_nxt;
      frc_r   <= frc_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tmp_r  <= tmp_nxt;
    prod_r <= prod_nxt;
  end

  assign sts.done = done_r;
  assign sts.pos  = pos_r;
  assign sts.vel  = vel_r;

endmodule
`default_nettype wire

FILE: sv/pei_merge.sv
// Merge stage: lifetime tracking, lane join and the output register.
`default_nettype none
module pei_merge
  import pei_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [FRAC_W-1:0] dt,
  input  wire logic [SPAN_W-1:0] span,
  input  wire lane_sts_t         sts [AXES],
  output logic                   busy,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata
);

  logic [WORD_W-1:0] life_r, life_nxt;
  logic              busy_r, busy_nxt;
  logic              pend_r, pend_nxt;
  logic              ovld_r, ovld_nxt;
  logic [OUT_W-1:0]  data_r;
  logic              all_done, load, dead;

  assign all_done = sts[0].done & sts[1].done & sts[2].done;
  assign load     = (pend_r | all_done) & (~ovld_r | out_tready);
  assign dead     = life_r[WORD_W-1] | (life_r == '0);

  always_comb begin
    life_nxt = life_r;
    if (in_acc) begin
      case (in_func)
        FN_INTEG: life_nxt = sat32(50'($signed(life_r)) - 50'({1'b0, dt}));
        FN_KILL:  life_nxt = '0;
        FN_SPAWN: life_nxt = {1'b0, span};
        default:  life_nxt = life_r;
      endcase
    end
    pend_nxt = (pend_r | all_done) & ~load;
    busy_nxt = in_acc | (busy_r & ~load);
    ovld_nxt = load | (ovld_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r <= '0;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      life_r <= life_nxt;
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {7'd0, dead, sts[2].vel, sts[1].vel, sts[0].vel,
                 sts[2].pos, sts[1].pos, sts[0].pos};
    end
  end

  assign busy       = busy_r;
  assign out_tvalid = ovld_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire

FILE: sv/particle_euler_integrator_unit.sv
// Single-particle explicit Euler integrator, Q16.16 fixed point, top level.
// Input stream: one command per transaction (add force, integrate, kill,
// spawn at position, set velocity) with an x/y/z value. Every transaction
// produces exactly one output transaction with position, velocity and the
// dead flag after the command.
// Three axis lanes run side by side; each owns its state, one 32x18
// multiplier and a radix-4 divider for force/mass (24 steps). The merge
// stage joins the lanes, tracks the lifetime and holds the output register.
// Each lane completes a non-integrate command in its idle state; an integrate
// steps through its states, dominated by the divider. One command is in flight at a time;
// in_tready returns high when its result enters the output register, so the
// next command is taken while that result still waits for out_tready.
// A stalled receiver holds the result in the output register and, once a
// second result is ready, the lanes wait and in_tready stays low.
// Reset (synchronous, rst_n low) clears the state; the particle starts
// dead at the origin with zero velocity, and registers take their defaults.
// The user must write registers over the APB-style port only while idle; the block does not enforce it.
`default_nettype none
module particle_euler_integrator_unit
  import pei_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,   // value_x, value_y, value_z
  input  wire logic [FUNC_W-1:0] in_tuser,   // func
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, is_dead
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [WORD_W-1:0] accel_r [AXES];
  logic [MASS_W-1:0] mass_r;
  logic [FRAC_W-1:0] damp_r;
  logic [FRAC_W-1:0] dt_r;
  logic [SPAN_W-1:0] span_r;

  logic              wr_en;
  logic [RIDX_W-1:0] ridx;
  logic              in_acc;
  logic              busy;
  lane_cmd_t         cmd;
  lane_cfg_t         lcfg;
  lane_sts_t         sts [AXES];

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign ridx       = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r[0] <= '0;
      accel_r[1] <= '0;
      accel_r[2] <= '0;
      mass_r     <= MASS_ONE;
      damp_r     <= DAMP_RST;
      dt_r       <= DT_RST;
      span_r     <= SPAN_RST;
    end else if (wr_en) begin
      case (ridx)
        REG_ACCEL_X: accel_r[0] <= cfg_pwdata;
        REG_ACCEL_Y: accel_r[1] <= cfg_pwdata;
        REG_ACCEL_Z: accel_r[2] <= cfg_pwdata;
        REG_MASS:    mass_r <= (cfg_pwdata[MASS_W-1:0] == '0) ? MASS_ONE
                                                              : cfg_pwdata[MASS_W-1:0];
        REG_DAMP:    damp_r <= cfg_pwdata[FRAC_W-1:0];
        REG_DT:      dt_r   <= cfg_pwdata[FRAC_W-1:0];
        REG_SPAN:    span_r <= cfg_pwdata[SPAN_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ACCEL_X: cfg_prdata = accel_r[0];
      REG_ACCEL_Y: cfg_prdata = accel_r[1];
      REG_ACCEL_Z: cfg_prdata = accel_r[2];
      REG_MASS:    cfg_prdata = {1'b0, mass_r};
      REG_DAMP:    cfg_prdata = {15'd0, damp_r};
      REG_DT:      cfg_prdata = {15'd0, dt_r};
      REG_SPAN:    cfg_prdata = {1'b0, span_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_tready = ~busy;
  assign in_acc    = in_tvalid & in_tready;
  assign cmd.start = in_acc;
  assign cmd.func  = in_tuser;
  assign lcfg.mass = mass_r;
  assign lcfg.damp = damp_r;
  assign lcfg.dt   = dt_r;

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    pei_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .value (in_tdata[WORD_W*i +: WORD_W]),
      .accel (accel_r[i]),
      .cfg   (lcfg),
      .sts   (sts[i])
    );
  end

  pei_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_func    (in_tuser),
    .dt         (dt_r),
    .span       (span_r),
    .sts        (sts),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

FILE: sv/pei_checker.sv
// Port-level checks for the integrator, bound to the top level.
`default_nettype none
module pei_checker
  import pei_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  // output held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while one is in flight");

  // a result only appears for a command that was taken
  a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a pending transaction");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind particle_euler_integrator_unit pei_checker u_pei_checker (.*);
`default_nettype wire
